// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property forms for the checkers, clocked on clk, idle in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/eac_pkg.sv
// ----------------------------------------------------------------------------
// eac_pkg
// types, constants and helpers of the euler angle composition datapath
// ----------------------------------------------------------------------------
`default_nettype none

package eac_pkg;

    localparam int ROT_W      = 34;   // rotation cordic x, y, z
    localparam int VEC_W      = 35;   // vectoring cordic x, y
    localparam int SC_W       = 17;   // q1.15 value plus room for +1
    localparam int SQRT_STEPS = 31;   // result bits of the square root

    localparam logic signed [ROT_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [ROT_W-1:0] TURN_QUARTER    = 34'sd1073741824;
    localparam logic signed [ROT_W-1:0] TURN_HALF       = 34'sd2147483648;
    localparam logic signed [SC_W-1:0]  ONE_Q15         = 17'sd32768;
    localparam logic [31:0]             HALF_TURN_U     = 32'h8000_0000;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_LOCK_UP,
        MODE_LOCK_DOWN
    } mode_t;

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
        logic                    flip;
    } rot_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [31:0]             z;
        logic                    zero;
    } vec_t;

    typedef struct packed {
        logic [61:0] rad;
        logic [33:0] rem;
        logic [30:0] root;
    } sqrt_t;

    typedef struct packed {
        logic signed [SC_W-1:0] c00;
        logic signed [SC_W-1:0] c01;
        logic signed [SC_W-1:0] c02;
        logic signed [SC_W-1:0] c11;
        logic signed [SC_W-1:0] c20;
        logic signed [SC_W-1:0] c21;
        logic signed [SC_W-1:0] c22;
        mode_t                  mode;
    } prod_t;

    // arctangent of 2^-i in turn units (2^32 a turn)
    function automatic logic [31:0] arc_tan(input int unsigned idx);
        logic [31:0] r;
        unique case (idx)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            24: r = 32'd41;
            25: r = 32'd20;
            26: r = 32'd10;
            27: r = 32'd5;
            28: r = 32'd3;
            29: r = 32'd1;
            30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // round half up by 2^s, clamp to plus or minus one in q15
    function automatic logic signed [SC_W-1:0] round_clamp(
        input logic signed [63:0] v,
        input int unsigned        s
    );
        logic signed [63:0] r;
        r = (v + (64'sd1 <<< (s - 1))) >>> s;
        if (r > 64'sd32768) r = 64'sd32768;
        if (r < -64'sd32768) r = -64'sd32768;
        return $signed(r[SC_W-1:0]);
    endfunction

    // vectoring start: zero vector flag, left half plane turned by pi
    function automatic vec_t vec_init(
        input logic signed [VEC_W-1:0] y,
        input logic signed [VEC_W-1:0] x
    );
        vec_t v;
        v.zero = (x == '0) && (y == '0);
        if (x[VEC_W-1]) begin
            v.x = -x;
            v.y = -y;
            v.z = HALF_TURN_U;
        end
        else begin
            v.x = x;
            v.y = y;
            v.z = '0;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/eac_rot_cell.sv
// ----------------------------------------------------------------------------
// eac_rot_cell
// one rotation-mode cordic iteration with its pipeline register
// ----------------------------------------------------------------------------
`default_nettype none

module eac_rot_cell #(
    parameter int STEP = 0
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire eac_pkg::rot_t d,
    output eac_pkg::rot_t      q
);

    localparam logic signed [eac_pkg::ROT_W-1:0] ARC =
        eac_pkg::ROT_W'(eac_pkg::arc_tan(STEP));

    eac_pkg::rot_t q_reg;
    eac_pkg::rot_t q_next;

    always_comb
    begin
        q_next = d;
        if (!d.z[eac_pkg::ROT_W-1])
        begin
            q_next.x = d.x - (d.y >>> STEP);
            q_next.y = d.y + (d.x >>> STEP);
            q_next.z = d.z - ARC;
        end
        else
        begin
            q_next.x = d.x + (d.y >>> STEP);
            q_next.y = d.y - (d.x >>> STEP);
            q_next.z = d.z + ARC;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// File: rtl/core/eac_vec_cell.sv
// ----------------------------------------------------------------------------
// eac_vec_cell
// one vectoring-mode cordic iteration with its pipeline register
// ----------------------------------------------------------------------------
`default_nettype none

module eac_vec_cell #(
    parameter int STEP = 0
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire eac_pkg::vec_t d,
    output eac_pkg::vec_t      q
);

    localparam logic [31:0] ARC = eac_pkg::arc_tan(STEP);

    eac_pkg::vec_t q_reg;
    eac_pkg::vec_t q_next;

    always_comb
    begin
        q_next = d;
        if (!d.y[eac_pkg::VEC_W-1])
        begin
            q_next.x = d.x + (d.y >>> STEP);
            q_next.y = d.y - (d.x >>> STEP);
            q_next.z = d.z + ARC;
        end
        else
        begin
            q_next.x = d.x - (d.y >>> STEP);
            q_next.y = d.y + (d.x >>> STEP);
            q_next.z = d.z - ARC;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// File: rtl/core/eac_sqrt_cell.sv
// ----------------------------------------------------------------------------
// eac_sqrt_cell
// one restoring square-root digit: two radicand bits in, one root bit out
// ----------------------------------------------------------------------------
`default_nettype none

module eac_sqrt_cell (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire eac_pkg::sqrt_t d,
    output eac_pkg::sqrt_t      q
);

    eac_pkg::sqrt_t q_reg;
    eac_pkg::sqrt_t q_next;
    logic [33:0]    cur;
    logic [33:0]    trial;

    always_comb
    begin
        cur   = {d.rem[31:0], d.rad[61:60]};
        trial = {1'b0, d.root, 2'b01};
        q_next.rad = {d.rad[59:0], 2'b00};
        if (cur >= trial)
        begin
            q_next.rem  = cur - trial;
            q_next.root = {d.root[29:0], 1'b1};
        end
        else
        begin
            q_next.rem  = cur;
            q_next.root = {d.root[29:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// File: rtl/core/euler_angle_composition.sv
// ----------------------------------------------------------------------------
// euler_angle_composition
// composes two z-x-y attitudes and returns the combined yaw, pitch and roll
// ----------------------------------------------------------------------------
//  channel | signals                            | beat
//  --------+------------------------------------+-------------------------
//  in      | in_valid, in_ready, first_*, second_* | one attitude pair
//  out     | out_valid, out_ready, out_*        | one combined attitude
//
//  a new beat is taken every cycle unless the pipe is frozen; the depth is
//  set by the two cordic cell chains (rotation, vectoring) and the 31-cell
//  square-root chain for the pitch cosine
//  the whole pipe advances together; it freezes only while out_valid is
//  high and out_ready low, so in_ready follows out_ready combinationally
//  reset clears the per-stage valid bits only; datapath registers hold
// ----------------------------------------------------------------------------
`default_nettype none

module euler_angle_composition #(
    parameter int ANGLE_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [ANGLE_WIDTH-1:0] first_yaw,
    input  wire logic signed [ANGLE_WIDTH-1:0] first_pitch,
    input  wire logic signed [ANGLE_WIDTH-1:0] first_roll,
    input  wire logic signed [ANGLE_WIDTH-1:0] second_yaw,
    input  wire logic signed [ANGLE_WIDTH-1:0] second_pitch,
    input  wire logic signed [ANGLE_WIDTH-1:0] second_roll,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [ANGLE_WIDTH-1:0]      out_yaw,
    output logic signed [ANGLE_WIDTH-1:0]      out_pitch,
    output logic signed [ANGLE_WIDTH-1:0]      out_roll
);

    localparam int ROT_W = eac_pkg::ROT_W;
    localparam int VEC_W = eac_pkg::VEC_W;
    localparam int SC_W  = eac_pkg::SC_W;
    localparam int SQ_N  = eac_pkg::SQRT_STEPS;
    localparam int SH    = 32 - ANGLE_WIDTH;
    localparam int LAT   = 2 * CORDIC_STEPS + 41;
    localparam logic [32:0] RND = (33'd1 << SH) >> 1;

    // pair product slots of one attitude
    localparam int PP_SHSP = 0;
    localparam int PP_CHSP = 1;
    localparam int PP_CHCR = 2;
    localparam int PP_SHCR = 3;
    localparam int PP_SHSR = 4;
    localparam int PP_CHSR = 5;
    localparam int PP_SHCP = 6;
    localparam int PP_CHCP = 7;
    localparam int PP_CPSR = 8;
    localparam int PP_CPCR = 9;

    // product entries kept: c00 c01 c02 c11 c20 c21 c22
    localparam int ROW_IDX [7] = '{0, 0, 0, 1, 2, 2, 2};
    localparam int COL_IDX [7] = '{0, 1, 2, 1, 0, 1, 2};

    // binary angle of the top 32 bits back to the port width, half up
    function automatic logic [ANGLE_WIDTH-1:0] to_field(input logic [31:0] z);
        logic [32:0] v;
        v = {1'b0, z} + RND;
        return v[SH +: ANGLE_WIDTH];
    endfunction

    // ---------------------------------------------------------------- control
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en        = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // ---------------------------------------------- fold angles into +-quarter
    logic [ANGLE_WIDTH-1:0] ang_in [6];
    eac_pkg::rot_t          fold_next [6];
    eac_pkg::rot_t          fold_reg [6];

    assign ang_in[0] = first_yaw;
    assign ang_in[1] = first_pitch;
    assign ang_in[2] = first_roll;
    assign ang_in[3] = second_yaw;
    assign ang_in[4] = second_pitch;
    assign ang_in[5] = second_roll;

    always_comb
    begin
        for (int l = 0; l < 6; l++)
        begin
            fold_next[l].x    = eac_pkg::CORDIC_GAIN_Q30;
            fold_next[l].y    = '0;
            fold_next[l].z    = ROT_W'(signed'(32'(ang_in[l]) << SH));
            fold_next[l].flip = 1'b0;
            if (fold_next[l].z > eac_pkg::TURN_QUARTER)
            begin
                fold_next[l].z    = fold_next[l].z - eac_pkg::TURN_HALF;
                fold_next[l].flip = 1'b1;
            end
            else if (fold_next[l].z < -eac_pkg::TURN_QUARTER)
            begin
                fold_next[l].z    = fold_next[l].z + eac_pkg::TURN_HALF;
                fold_next[l].flip = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fold_reg <= fold_next;
        end
    end

    // -------------------------------------------------- sin/cos cell chains
    // lanes: first yaw, pitch, roll, then second yaw, pitch, roll
    eac_pkg::rot_t rot_d [6][CORDIC_STEPS+1];

    for (genvar l = 0; l < 6; l++)
    begin : g_rot_lane
        assign rot_d[l][0] = fold_reg[l];
        for (genvar s = 0; s < CORDIC_STEPS; s++)
        begin : g_rot_step
            eac_rot_cell #(.STEP(s)) u_cell (
                .clk (clk),
                .en  (en),
                .d   (rot_d[l][s]),
                .q   (rot_d[l][s+1])
            );
        end
    end

    logic signed [SC_W-1:0] sin_reg [6];
    logic signed [SC_W-1:0] cos_reg [6];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 6; l++)
            begin
                if (rot_d[l][CORDIC_STEPS].flip)
                begin
                    cos_reg[l] <= eac_pkg::round_clamp(
                        -64'(rot_d[l][CORDIC_STEPS].x), 15);
                    sin_reg[l] <= eac_pkg::round_clamp(
                        -64'(rot_d[l][CORDIC_STEPS].y), 15);
                end
                else
                begin
                    cos_reg[l] <= eac_pkg::round_clamp(64'(rot_d[l][CORDIC_STEPS].x), 15);
                    sin_reg[l] <= eac_pkg::round_clamp(64'(rot_d[l][CORDIC_STEPS].y), 15);
                end
            end
        end
    end

    // ------------------------------------------------ attitude matrices
    // pair products
    logic signed [33:0]     pp_reg  [2][10];
    logic signed [SC_W-1:0] sp1_reg [2];
    logic signed [SC_W-1:0] sr1_reg [2];
    logic signed [SC_W-1:0] cr1_reg [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int t = 0; t < 2; t++)
            begin
                pp_reg[t][PP_SHSP] <= sin_reg[3*t] * sin_reg[3*t+1];
                pp_reg[t][PP_CHSP] <= cos_reg[3*t] * sin_reg[3*t+1];
                pp_reg[t][PP_CHCR] <= cos_reg[3*t] * cos_reg[3*t+2];
                pp_reg[t][PP_SHCR] <= sin_reg[3*t] * cos_reg[3*t+2];
                pp_reg[t][PP_SHSR] <= sin_reg[3*t] * sin_reg[3*t+2];
                pp_reg[t][PP_CHSR] <= cos_reg[3*t] * sin_reg[3*t+2];
                pp_reg[t][PP_SHCP] <= sin_reg[3*t] * cos_reg[3*t+1];
                pp_reg[t][PP_CHCP] <= cos_reg[3*t] * cos_reg[3*t+1];
                pp_reg[t][PP_CPSR] <= cos_reg[3*t+1] * sin_reg[3*t+2];
                pp_reg[t][PP_CPCR] <= cos_reg[3*t+1] * cos_reg[3*t+2];
                sp1_reg[t] <= sin_reg[3*t+1];
                sr1_reg[t] <= sin_reg[3*t+2];
                cr1_reg[t] <= cos_reg[3*t+2];
            end
        end
    end

    // triple products (q45) and pass-through of the pair products
    logic signed [50:0]     tp_reg  [2][4];
    logic signed [33:0]     pp2_reg [2][10];
    logic signed [SC_W-1:0] sp2_reg [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int t = 0; t < 2; t++)
            begin
                tp_reg[t][0] <= pp_reg[t][PP_SHSP] * sr1_reg[t];
                tp_reg[t][1] <= pp_reg[t][PP_SHSP] * cr1_reg[t];
                tp_reg[t][2] <= pp_reg[t][PP_CHSP] * sr1_reg[t];
                tp_reg[t][3] <= pp_reg[t][PP_CHSP] * cr1_reg[t];
                pp2_reg[t]   <= pp_reg[t];
                sp2_reg[t]   <= sp1_reg[t];
            end
        end
    end

    // entries: q45 sums rounded to q15
    logic signed [SC_W-1:0] mat_reg [2][3][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int t = 0; t < 2; t++)
            begin
                mat_reg[t][0][0] <= eac_pkg::round_clamp(
                    (64'(pp2_reg[t][PP_CHCR]) <<< 15) - 64'(tp_reg[t][0]), 30);
                mat_reg[t][0][1] <= eac_pkg::round_clamp(
                    -(64'(pp2_reg[t][PP_SHCP]) <<< 15), 30);
                mat_reg[t][0][2] <= eac_pkg::round_clamp(
                    (64'(pp2_reg[t][PP_CHSR]) <<< 15) + 64'(tp_reg[t][1]), 30);
                mat_reg[t][1][0] <= eac_pkg::round_clamp(
                    (64'(pp2_reg[t][PP_SHCR]) <<< 15) + 64'(tp_reg[t][2]), 30);
                mat_reg[t][1][1] <= eac_pkg::round_clamp(
                    64'(pp2_reg[t][PP_CHCP]) <<< 15, 30);
                mat_reg[t][1][2] <= eac_pkg::round_clamp(
                    (64'(pp2_reg[t][PP_SHSR]) <<< 15) - 64'(tp_reg[t][3]), 30);
                mat_reg[t][2][0] <= eac_pkg::round_clamp(
                    -(64'(pp2_reg[t][PP_CPSR]) <<< 15), 30);
                // sin(pitch) scaled by one, one: the sine itself
                mat_reg[t][2][1] <= sp2_reg[t];
                mat_reg[t][2][2] <= eac_pkg::round_clamp(
                    64'(pp2_reg[t][PP_CPCR]) <<< 15, 30);
            end
        end
    end

    // -------------------------------------------------- matrix product
    logic signed [33:0]     pr_reg [7][3];
    logic signed [SC_W-1:0] c_reg  [7];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int e = 0; e < 7; e++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pr_reg[e][k] <= mat_reg[0][ROW_IDX[e]][k] * mat_reg[1][k][COL_IDX[e]];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int e = 0; e < 7; e++)
            begin
                c_reg[e] <= eac_pkg::round_clamp(
                    64'(pr_reg[e][0]) + 64'(pr_reg[e][1]) + 64'(pr_reg[e][2]), 15);
            end
        end
    end

    // --------------------------------------- lock detect, sqrt(1 - s^2) chain
    eac_pkg::prod_t q_data_next;
    eac_pkg::prod_t q_data_reg;
    eac_pkg::sqrt_t q_sqrt_next;
    eac_pkg::sqrt_t q_sqrt_reg;
    logic signed [33:0] s_sq;
    logic [30:0]        rest;

    always_comb
    begin
        q_data_next.c00 = c_reg[0];
        q_data_next.c01 = c_reg[1];
        q_data_next.c02 = c_reg[2];
        q_data_next.c11 = c_reg[3];
        q_data_next.c20 = c_reg[4];
        q_data_next.c21 = c_reg[5];
        q_data_next.c22 = c_reg[6];
        priority if (c_reg[5] >= eac_pkg::ONE_Q15)
            q_data_next.mode = eac_pkg::MODE_LOCK_UP;
        else if (c_reg[5] <= -eac_pkg::ONE_Q15)
            q_data_next.mode = eac_pkg::MODE_LOCK_DOWN;
        else
            q_data_next.mode = eac_pkg::MODE_NORMAL;

        // s^2 never exceeds one in q30, so the rest stays non-negative
        s_sq = c_reg[5] * c_reg[5];
        rest = 31'(34'sd1073741824 - s_sq);
        q_sqrt_next.rad  = {1'b0, rest, 30'd0};
        q_sqrt_next.rem  = '0;
        q_sqrt_next.root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_data_reg <= q_data_next;
            q_sqrt_reg <= q_sqrt_next;
        end
    end

    eac_pkg::sqrt_t sq_d [SQ_N+1];
    eac_pkg::prod_t dly_reg [SQ_N];

    assign sq_d[0] = q_sqrt_reg;

    for (genvar s = 0; s < SQ_N; s++)
    begin : g_sqrt_step
        eac_sqrt_cell u_cell (
            .clk (clk),
            .en  (en),
            .d   (sq_d[s]),
            .q   (sq_d[s+1])
        );
    end

    // matrix data rides alongside the square-root cells
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= q_data_reg;
            for (int k = 1; k < SQ_N; k++)
            begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    // ------------------------------------------------ atan2 cell chains
    // lanes: yaw, pitch, roll
    eac_pkg::prod_t          pd;
    eac_pkg::vec_t           v0_next [3];
    eac_pkg::vec_t           v0_reg  [3];
    eac_pkg::mode_t          mode_dly_reg [CORDIC_STEPS+1];
    logic signed [VEC_W-1:0] k_c00;
    logic signed [VEC_W-1:0] k_c01;
    logic signed [VEC_W-1:0] k_c02;
    logic signed [VEC_W-1:0] k_c11;
    logic signed [VEC_W-1:0] k_c20;
    logic signed [VEC_W-1:0] k_c21;
    logic signed [VEC_W-1:0] k_c22;

    assign pd = dly_reg[SQ_N-1];

    always_comb
    begin
        k_c00 = VEC_W'(pd.c00) <<< 15;
        k_c01 = VEC_W'(pd.c01) <<< 15;
        k_c02 = VEC_W'(pd.c02) <<< 15;
        k_c11 = VEC_W'(pd.c11) <<< 15;
        k_c20 = VEC_W'(pd.c20) <<< 15;
        k_c21 = VEC_W'(pd.c21) <<< 15;
        k_c22 = VEC_W'(pd.c22) <<< 15;
        if (pd.mode == eac_pkg::MODE_NORMAL)
            v0_next[0] = eac_pkg::vec_init(-k_c01, k_c11);
        else
            v0_next[0] = eac_pkg::vec_init(k_c02, k_c00);
        v0_next[1] = eac_pkg::vec_init(k_c21,
                                       $signed(VEC_W'(sq_d[SQ_N].root)));
        v0_next[2] = eac_pkg::vec_init(-k_c20, k_c22);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v0_reg          <= v0_next;
            mode_dly_reg[0] <= pd.mode;
            for (int k = 1; k <= CORDIC_STEPS; k++)
            begin
                mode_dly_reg[k] <= mode_dly_reg[k-1];
            end
        end
    end

    eac_pkg::vec_t vec_d [3][CORDIC_STEPS+1];

    for (genvar v = 0; v < 3; v++)
    begin : g_vec_lane
        assign vec_d[v][0] = v0_reg[v];
        for (genvar s = 0; s < CORDIC_STEPS; s++)
        begin : g_vec_step
            eac_vec_cell #(.STEP(s)) u_cell (
                .clk (clk),
                .en  (en),
                .d   (vec_d[v][s]),
                .q   (vec_d[v][s+1])
            );
        end
    end

    // ------------------------------------------------------- output stage
    logic [31:0]            z_yaw;
    logic [31:0]            z_pitch;
    logic [31:0]            z_roll;
    logic [ANGLE_WIDTH-1:0] yaw_next;
    logic [ANGLE_WIDTH-1:0] pitch_next;
    logic [ANGLE_WIDTH-1:0] roll_next;
    logic [ANGLE_WIDTH-1:0] out_yaw_reg;
    logic [ANGLE_WIDTH-1:0] out_pitch_reg;
    logic [ANGLE_WIDTH-1:0] out_roll_reg;

    always_comb
    begin
        // a zero vector gives angle zero
        z_yaw   = vec_d[0][CORDIC_STEPS].zero ? 32'd0 : vec_d[0][CORDIC_STEPS].z;
        z_pitch = vec_d[1][CORDIC_STEPS].zero ? 32'd0 : vec_d[1][CORDIC_STEPS].z;
        z_roll  = vec_d[2][CORDIC_STEPS].zero ? 32'd0 : vec_d[2][CORDIC_STEPS].z;
        unique case (mode_dly_reg[CORDIC_STEPS])
            eac_pkg::MODE_LOCK_UP:
            begin
                yaw_next   = to_field(z_yaw);
                pitch_next = to_field(32'h4000_0000);
                roll_next  = '0;
            end
            eac_pkg::MODE_LOCK_DOWN:
            begin
                yaw_next   = to_field(32'd0 - z_yaw);
                pitch_next = to_field(32'hC000_0000);
                roll_next  = '0;
            end
            default:
            begin
                yaw_next   = to_field(z_yaw);
                pitch_next = to_field(z_pitch);
                roll_next  = to_field(z_roll);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_yaw_reg   <= yaw_next;
            out_pitch_reg <= pitch_next;
            out_roll_reg  <= roll_next;
        end
    end

    assign out_yaw   = out_yaw_reg;
    assign out_pitch = out_pitch_reg;
    assign out_roll  = out_roll_reg;

endmodule

`default_nettype wire

// File: rtl/core/eac_checker.sv
// ----------------------------------------------------------------------------
// eac_checker
// port-level checks of the composition block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module eac_checker #(
    parameter int ANGLE_WIDTH = 16
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic signed [ANGLE_WIDTH-1:0] out_pitch
);

    localparam logic signed [ANGLE_WIDTH:0] QUARTER = (ANGLE_WIDTH+1)'(1) <<< (ANGLE_WIDTH - 2);

    // a result beat waits until taken
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // input side stalls only behind a stalled result
    `ASSERT_IMPL(a_ready_stall, 1'b1, in_ready == (!out_valid || out_ready))
    // pitch stays within plus or minus a quarter turn
    `ASSERT_IMPL(a_pitch_range, out_valid,
                 ((ANGLE_WIDTH+1)'(out_pitch) <= QUARTER) &&
                 ((ANGLE_WIDTH+1)'(out_pitch) >= -QUARTER))
    // no result beat right out of reset
    `ASSERT_IMPL(a_reset_empty, $past(!rst_n), !out_valid)

endmodule

bind euler_angle_composition eac_checker #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_eac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pitch (out_pitch)
);

`default_nettype wire

// File: test/euler_angle_composition_tb.sv
// ----------------------------------------------------------------------------
// euler_angle_composition_tb
// drives attitude pairs into the composition pipe with random gaps and
// output stalls, predicts each combined yaw, pitch and roll bit for bit and
// compares every output beat in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module euler_angle_composition_tb;

    localparam int AW          = 16;
    localparam int STEPS       = 16;
    localparam int LATENCY     = 2 * STEPS + 41;
    localparam int NUM_RANDOM  = 950;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint Q15_ONE = 32768;
    localparam longint GAIN    = 652032874;
    localparam longint QUARTER = 1073741824;
    localparam longint HALF    = 64'sd2147483648;

    typedef logic signed [AW-1:0] ang_t;

    typedef struct packed {
        ang_t yaw;
        ang_t pitch;
        ang_t roll;
    } attitude_t;

    // one directed row: two attitudes, plus a typed-in pitch and roll where
    // they are exact (gimbal lock); yaw there still carries cordic residue
    typedef struct {
        attitude_t first;
        attitude_t second;
        bit        known;
        attitude_t answer;
    } vector_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    ang_t first_yaw, first_pitch, first_roll;
    ang_t second_yaw, second_pitch, second_roll;
    logic out_valid;
    logic out_ready;
    ang_t out_yaw, out_pitch, out_roll;

    attitude_t pending_attitudes[$];
    int        error_count;
    int        beats_sent;
    int        beats_checked;
    int        lock_count;
    longint    cycle_count;
    bit        calm;           // long stretch with no idling on either side

    euler_angle_composition #(
        .ANGLE_WIDTH (AW),
        .CORDIC_STEPS(STEPS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .first_yaw   (first_yaw),
        .first_pitch (first_pitch),
        .first_roll  (first_roll),
        .second_yaw  (second_yaw),
        .second_pitch(second_pitch),
        .second_roll (second_roll),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_yaw     (out_yaw),
        .out_pitch   (out_pitch),
        .out_roll    (out_roll)
    );

    // ------------------------------------------------------------------------
    // fixed-point predictor
    // ------------------------------------------------------------------------

    function automatic longint atan_step(input int idx);
        longint t[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                          21354465, 10679838, 5340245, 2670163, 1335087,
                          667544, 333772, 166886, 83443, 41722, 20861, 10430,
                          5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5,
                          3, 1, 1, 0};
        return t[idx];
    endfunction

    // round half up by 2^s, then saturate to plus or minus one in q15
    function automatic longint q15_round(input longint v, input int s);
        longint r;
        r = (v + (longint'(1) <<< (s - 1))) >>> s;
        if (r > Q15_ONE) r = Q15_ONE;
        if (r < -Q15_ONE) r = -Q15_ONE;
        return r;
    endfunction

    // rotation-mode cordic on a 32-bit turn angle
    task automatic sin_cos(input logic [31:0] a, output longint sn, output longint cs);
        longint z, x, y, nx;
        bit     flip;
        z = a[31] ? longint'(a) - 64'sd4294967296 : longint'(a);
        flip = 0;
        x = GAIN;
        y = 0;
        if (z > QUARTER)
        begin
            z -= HALF;
            flip = 1;
        end
        else if (z < -QUARTER)
        begin
            z += HALF;
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= atan_step(i);
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += atan_step(i);
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cs = q15_round(x, 15);
        sn = q15_round(y, 15);
    endtask

    // vectoring-mode cordic, result in 32-bit turn units
    function automatic logic [31:0] heading_of(input longint y, input longint x);
        logic [31:0] z;
        longint      nx;
        z = '0;
        if (x == 0 && y == 0) return '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += 32'(atan_step(i));
            end
            else
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= 32'(atan_step(i));
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
            begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // 32-bit turn to field width, rounded half up, wrapping
    function automatic ang_t to_angle(input logic [31:0] z);
        logic [32:0] v;
        v = {1'b0, z} + (33'd1 << (32 - AW - 1));
        return ang_t'(v >> (32 - AW));
    endfunction

    task automatic rotation_of(input attitude_t a, output longint m[3][3]);
        longint sh, ch, sp, cp, sr, cr;
        sin_cos({a.yaw, 16'h0}, sh, ch);
        sin_cos({a.pitch, 16'h0}, sp, cp);
        sin_cos({a.roll, 16'h0}, sr, cr);
        m[0][0] = q15_round(ch * cr * Q15_ONE - sh * sp * sr, 30);
        m[0][1] = q15_round(-sh * cp * Q15_ONE, 30);
        m[0][2] = q15_round(ch * sr * Q15_ONE + sh * sp * cr, 30);
        m[1][0] = q15_round(sh * cr * Q15_ONE + ch * sp * sr, 30);
        m[1][1] = q15_round(ch * cp * Q15_ONE, 30);
        m[1][2] = q15_round(sh * sr * Q15_ONE - ch * sp * cr, 30);
        m[2][0] = q15_round(-cp * sr * Q15_ONE, 30);
        m[2][1] = q15_round(sp * Q15_ONE * Q15_ONE, 30);
        m[2][2] = q15_round(cp * cr * Q15_ONE, 30);
    endtask

    // combined attitude of two z-x-y rotations, with the gimbal lock cases
    task automatic compose_attitudes(input attitude_t f, input attitude_t s,
                                     output attitude_t r, output bit locked);
        longint      a[3][3], b[3][3], c[3][3];
        longint      sp;
        logic [63:0] co;
        rotation_of(f, a);
        rotation_of(s, b);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                c[i][j] = q15_round(a[i][0] * b[0][j] + a[i][1] * b[1][j]
                                    + a[i][2] * b[2][j], 15);
        locked = 1;
        if (c[2][1] >= Q15_ONE)
        begin
            r.yaw   = to_angle(heading_of(c[0][2] * Q15_ONE, c[0][0] * Q15_ONE));
            r.pitch = to_angle(32'(QUARTER));
            r.roll  = '0;
        end
        else if (c[2][1] <= -Q15_ONE)
        begin
            r.yaw   = to_angle(32'd0 - heading_of(c[0][2] * Q15_ONE, c[0][0] * Q15_ONE));
            r.pitch = to_angle(32'd0 - 32'(QUARTER));
            r.roll  = '0;
        end
        else
        begin
            locked = 0;
            sp = c[2][1];
            co = int_sqrt(((64'd1 << 30) - 64'(sp * sp)) << 30);
            r.yaw   = to_angle(heading_of(-c[0][1] * Q15_ONE, c[1][1] * Q15_ONE));
            r.pitch = to_angle(heading_of(sp * Q15_ONE, longint'(co)));
            r.roll  = to_angle(heading_of(-c[2][0] * Q15_ONE, c[2][2] * Q15_ONE));
        end
    endtask

    // ------------------------------------------------------------------------
    // clock, reset, cycle limit
    // ------------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // output side: random stalls, compare each beat with the oldest prediction
    // ------------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n) out_ready <= calm || ($urandom_range(99) >= 26);
    end

    always @(posedge clk)
    begin
        attitude_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_attitudes.size() == 0)
            begin
                $display("%0t: unexpected beat yaw %0d pitch %0d roll %0d",
                         $time, out_yaw, out_pitch, out_roll);
                error_count++;
            end
            else
            begin
                want = pending_attitudes.pop_front();
                if (out_yaw !== want.yaw)
                begin
                    $display("%0t: yaw expected %0d actual %0d", $time, want.yaw, out_yaw);
                    error_count++;
                end
                if (out_pitch !== want.pitch)
                begin
                    $display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
                             out_pitch);
                    error_count++;
                end
                if (out_roll !== want.roll)
                begin
                    $display("%0t: roll expected %0d actual %0d", $time, want.roll, out_roll);
                    error_count++;
                end
                beats_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // present one pair, hold it until taken; prediction queued at acceptance
    // valid drops only while idling, so back-to-back beats keep it high
    task automatic send_pair(input attitude_t f, input attitude_t s,
                             input bit known, input attitude_t answer);
        attitude_t r;
        bit        locked;
        compose_attitudes(f, s, r, locked);
        if (known && (r.pitch !== answer.pitch || r.roll !== answer.roll))
        begin
            $display("%0t: predictor expected pitch/roll %0d/%0d actual %0d/%0d", $time,
                     answer.pitch, answer.roll, r.pitch, r.roll);
            error_count++;
        end
        lock_count += locked;
        while (!calm && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        first_yaw    <= f.yaw;
        first_pitch  <= f.pitch;
        first_roll   <= f.roll;
        second_yaw   <= s.yaw;
        second_pitch <= s.pitch;
        second_roll  <= s.roll;
        do @(posedge clk); while (!in_ready);
        pending_attitudes.push_back(r);
        beats_sent++;
        @(negedge clk);
    endtask

    function automatic ang_t any_angle();
        case ($urandom_range(5))
            0: return ang_t'(16'h8000);
            1: return ang_t'(16'h7fff);
            2: return ang_t'($urandom_range(2) * 16384 - 16384);  // quarter turns
            3: return ang_t'($urandom_range(64) - 32);            // near zero
            default: return ang_t'($urandom);
        endcase
    endfunction

    vector_row_t directed_rows[] = '{
        // all angles zero
        '{'{0, 0, 0}, '{0, 0, 0}, 0, '{0, 0, 0}},
        // two eighth-turn pitches, summing to a quarter turn
        '{'{0, 8192, 0}, '{0, 8192, 0}, 0, '{0, 0, 0}},
        // a quarter-turn pitch alone: gimbal lock up, roll zero
        '{'{0, 16384, 0}, '{0, 0, 0}, 1, '{0, 16384, 0}},
        // gimbal lock down
        '{'{0, -16384, 0}, '{0, 0, 0}, 1, '{0, -16384, 0}},
        '{'{0, -8192, 0}, '{0, -8192, 0}, 0, '{0, 0, 0}},
        // yaw near pi, negated in lock down
        '{'{-32768, -16384, 0}, '{0, 0, 0}, 0, '{0, 0, 0}},
        '{'{-32768, 16384, 0}, '{0, 0, 0}, 0, '{0, 0, 0}},
        // field extremes
        '{'{-32768, -32768, -32768}, '{-32768, -32768, -32768}, 0, '{0, 0, 0}},
        '{'{32767, 32767, 32767}, '{32767, 32767, 32767}, 0, '{0, 0, 0}},
        '{'{-32768, 32767, -32768}, '{32767, -32768, 32767}, 0, '{0, 0, 0}},
        '{'{-1, -1, -1}, '{1, 1, 1}, 0, '{0, 0, 0}},
        '{'{21845, -21846, 10922}, '{-10923, 21845, -21846}, 0, '{0, 0, 0}},
        // single axes, then yaw and roll together
        '{'{8192, 0, 0}, '{8192, 0, 0}, 0, '{0, 0, 0}},
        '{'{0, 0, 8192}, '{0, 0, -4096}, 0, '{0, 0, 0}},
        '{'{0, 4096, 0}, '{0, -12288, 0}, 0, '{0, 0, 0}},
        '{'{16384, 0, 16384}, '{-16384, 0, -16384}, 0, '{0, 0, 0}},
        // roll of pi with pitch lock
        '{'{0, 16384, -32768}, '{0, 0, 0}, 0, '{0, 0, 0}},
        '{'{12345, -16384, -6789}, '{0, 0, 0}, 0, '{0, 0, 0}}
    };

    initial
    begin
        attitude_t f, s, none;
        in_valid     = 1'b0;
        out_ready    = 1'b0;
        first_yaw    = '0;
        first_pitch  = '0;
        first_roll   = '0;
        second_yaw   = '0;
        second_pitch = '0;
        second_roll  = '0;
        error_count  = 0;
        beats_sent   = 0;
        beats_checked = 0;
        lock_count   = 0;
        cycle_count  = 0;
        calm         = 1'b0;
        none         = '0;
        @(posedge rst_n);
        @(negedge clk);

        foreach (directed_rows[i])
            send_pair(directed_rows[i].first, directed_rows[i].second,
                      directed_rows[i].known, directed_rows[i].answer);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            calm = (n >= 400 && n < 550);
            f = '{any_angle(), any_angle(), any_angle()};
            s = '{any_angle(), any_angle(), any_angle()};
            // steer some pairs into gimbal lock: pitches summing to a quarter turn
            if ($urandom_range(7) == 0)
            begin
                f.roll  = '0;
                s.yaw   = '0;
                s.pitch = ang_t'(($urandom_range(1) ? 16384 : -16384) - f.pitch);
            end
            send_pair(f, s, 0, none);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_attitudes.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("%0d attitude pairs sent, %0d combined attitudes checked, %0d in gimbal lock",
                 beats_sent, beats_checked, lock_count);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/eac_pkg.sv
rtl/core/eac_rot_cell.sv
rtl/core/eac_vec_cell.sv
rtl/core/eac_sqrt_cell.sv
rtl/core/euler_angle_composition.sv
rtl/core/eac_checker.sv
test/euler_angle_composition_tb.sv
